### rtl/twm2d_pkg.sv
// Package for the timed-window 2-D median filter.
// Holds the controller state type, the history entry layout and the fixed field widths.
// No dependencies.
package twm2d_pkg;

    localparam int COORD_W = 16;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int COUNT_W = 8;

    // Flipping the sign bit maps two's complement order onto unsigned order.
    localparam logic [COORD_W-1:0] SIGN_FLIP = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_COUNT,
        ST_SELECT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  t;
    } entry_t;

endpackage

### rtl/timed_window_median_2d.sv
// Timed-window 2-D median filter: history memory, window test and bit-serial rank select.
// Depends on twm2d_pkg for the state type, entry layout and field widths.
//
// One request at a time: the next request is taken once the previous one has moved into
// the output register. Each request takes seventeen sweeps over the single read port of
// the history memory.
// Reset (aresetn, synchronous, active low) clears the controller, the fill count, the write
// slot and the output valid, and sets window_ticks to 100; the memory itself is not cleared.
module timed_window_median_2d
    import twm2d_pkg::*;
#(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [WIN_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_gaze_x,
    input  logic signed [COORD_W-1:0] s_gaze_y,
    input  logic [TIME_W-1:0]         s_sample_time,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_median_x,
    output logic signed [COORD_W-1:0] m_median_y,
    output logic [COUNT_W-1:0]        m_window_count
);

    // Index width for the memory and a counter width that can also hold the depth itself.
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);

    // The history memory: one packed word per entry, one write and one registered read.
    entry_t mem [HISTORY_DEPTH];
    entry_t rd_data_reg;

    state_t state_reg, state_next;

    logic [WIN_W-1:0]   win_reg;
    entry_t             new_reg;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    // Sweep control: scan_reg issues read addresses, rd_live_reg marks a data word in flight.
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               rd_live_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    // Rank select state. The prefixes are kept in offset binary; mask_reg covers the bits
    // already settled and bit_reg is the one-hot bit that the current sweep decides.
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   kx_reg, kx_next, ky_reg, ky_next;
    logic [CNT_W-1:0]   c0x_reg, c0x_next, c0y_reg, c0y_next;
    logic [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [COORD_W-1:0] mask_reg, mask_next, bit_reg, bit_next;

    logic                      m_valid_reg;
    logic [COORD_W-1:0]        mx_reg, my_reg;
    logic [COUNT_W-1:0]        mcnt_reg;

    logic issue, pass_end, mem_we, out_load, accept;
    logic in_scan;

    logic [TIME_W-1:0]  age;
    logic               entry_ok, selected;
    logic [COORD_W-1:0] xu, yu;
    logic               x_zero, y_zero;
    logic [CNT_W+COUNT_W-1:0] count_wide;
    logic [COUNT_W-1:0] count_sat;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_median_x     = mx_reg;
    assign m_median_y     = my_reg;
    assign m_window_count = mcnt_reg;

    // Next-state logic of the controller.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (pass_end) begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (pass_end && bit_reg[0]) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        in_scan  = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_WRITE:  mem_we   = 1'b1;
            ST_COUNT:  in_scan  = 1'b1;
            ST_SELECT: in_scan  = 1'b1;
            ST_FINISH: out_load = !m_valid_reg || m_ready;
            default:   in_scan  = 1'b0;
        endcase
        issue    = in_scan && (scan_reg < DEPTH_C);
        pass_end = in_scan && (scan_reg == DEPTH_C) && !rd_live_reg;
    end

    // Window test on the word just read. Entries are written in slot order from reset, so
    // an index below the fill count is exactly a written entry. Ages wrap modulo 2^32.
    always_comb begin
        age      = new_reg.t - rd_data_reg.t;
        entry_ok = CNT_W'(rd_idx_reg) < fill_reg;
        selected = rd_live_reg && entry_ok && (age <= TIME_W'(win_reg));
        xu       = rd_data_reg.x ^ SIGN_FLIP;
        yu       = rd_data_reg.y ^ SIGN_FLIP;
        x_zero   = selected && (((xu ^ px_reg) & mask_reg) == '0) && ((xu & bit_reg) == '0);
        y_zero   = selected && (((yu ^ py_reg) & mask_reg) == '0) && ((yu & bit_reg) == '0);
        count_wide = (CNT_W+COUNT_W)'(count_reg);
        count_sat  = (count_wide > (CNT_W+COUNT_W)'(COUNT_MAX)) ? COUNT_MAX
                                                                : count_wide[COUNT_W-1:0];
    end

    // Datapath next values.
    always_comb begin
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        scan_next   = scan_reg;
        count_next  = count_reg;
        kx_next     = kx_reg;
        ky_next     = ky_reg;
        c0x_next    = c0x_reg;
        c0y_next    = c0y_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        mask_next   = mask_reg;
        bit_next    = bit_reg;

        if (mem_we) begin
            oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
            if (fill_reg != DEPTH_C) begin
                fill_next = fill_reg + 1'b1;
            end
            scan_next  = '0;
            count_next = '0;
            c0x_next   = '0;
            c0y_next   = '0;
        end

        if (issue) begin
            scan_next = scan_reg + 1'b1;
        end

        // Accumulate over the sweep in progress.
        if (state_reg == ST_COUNT && selected) begin
            count_next = count_reg + 1'b1;
        end
        if (state_reg == ST_SELECT) begin
            if (x_zero) begin
                c0x_next = c0x_reg + 1'b1;
            end
            if (y_zero) begin
                c0y_next = c0y_reg + 1'b1;
            end
        end

        if (pass_end) begin
            scan_next = '0;
            c0x_next  = '0;
            c0y_next  = '0;
            if (state_reg == ST_COUNT) begin
                // The wanted rank is count/2: the upper median for even counts.
                kx_next   = count_reg >> 1;
                ky_next   = count_reg >> 1;
                px_next   = '0;
                py_next   = '0;
                mask_next = '0;
                bit_next  = SIGN_FLIP;
            end else begin
                // If the rank lies beyond the entries with a zero here, the bit is a one.
                if (kx_reg >= c0x_reg) begin
                    px_next = px_reg | bit_reg;
                    kx_next = kx_reg - c0x_reg;
                end
                if (ky_reg >= c0y_reg) begin
                    py_next = py_reg | bit_reg;
                    ky_next = ky_reg - c0y_reg;
                end
                mask_next = mask_reg | bit_reg;
                bit_next  = bit_reg >> 1;
            end
        end
    end

    // History memory: written once per request, read once per sweep cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[oldest_reg] <= new_reg;
        end
        rd_data_reg <= mem[scan_reg[IDX_W-1:0]];
        rd_idx_reg  <= scan_reg[IDX_W-1:0];
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            new_reg.x <= s_gaze_x;
            new_reg.y <= s_gaze_y;
            new_reg.t <= s_sample_time;
        end
        count_reg <= count_next;
        kx_reg    <= kx_next;
        ky_reg    <= ky_next;
        c0x_reg   <= c0x_next;
        c0y_reg   <= c0y_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        mask_reg  <= mask_next;
        bit_reg   <= bit_next;
        if (out_load) begin
            mx_reg   <= px_reg ^ SIGN_FLIP;
            my_reg   <= py_reg ^ SIGN_FLIP;
            mcnt_reg <= count_sat;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= WIN_W'(100);
            oldest_reg  <= '0;
            fill_reg    <= '0;
            scan_reg    <= '0;
            rd_live_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            fill_reg    <= fill_next;
            scan_reg    <= scan_next;
            rd_live_reg <= issue;
            if (cfg_wr_en) begin
                win_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Read data is only in flight during a sweep.
    a_live_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_live_reg |-> (state_reg == ST_COUNT || state_reg == ST_SELECT))
        else $error("read data in flight outside a sweep");

    // The new sample is always in the window, and no more entries than written are counted.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SELECT) |-> (count_reg != '0 && count_reg <= fill_reg))
        else $error("window count out of range during rank select");

    // The rank stays inside the set of candidates.
    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SELECT) |-> (kx_reg < count_reg && ky_reg < count_reg))
        else $error("rank outside the selected entries");

    // A result appears only when the finishing state hands it over.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing state");

    // The fill count saturates at the depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_C)
        else $error("fill count beyond the history depth");

endmodule

### test/tb.sv
// Self-checking testbench for timed_window_median_2d: directed and random gaze samples with
// a scoreboard class that predicts the windowed medians. Depends on twm2d_pkg and the RTL.
module tb;
    import twm2d_pkg::*;

    localparam int HIST_DEPTH   = 128;
    // The drain allows a little more than one request takes.
    localparam int DRAIN_CYCLES = 2400;
    localparam int HOLD_CYCLES  = 10000;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic [COUNT_W-1:0]        cnt;
    } median_t;

    // Scoreboard: keeps its own copy of the history, predicts the medians of each accepted
    // request and compares every accepted result with the oldest prediction.
    class median_board;
        logic signed [COORD_W-1:0] hist_x [HIST_DEPTH];
        logic signed [COORD_W-1:0] hist_y [HIST_DEPTH];
        logic [TIME_W-1:0]         hist_t [HIST_DEPTH];
        bit                        hist_used [HIST_DEPTH];
        int                        next_slot;
        logic [WIN_W-1:0]          window_ticks;
        median_t                   pending[$];
        int                        errors;
        int                        results_seen;

        function new();
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_used[i] = 1'b0;
            end
            next_slot    = 0;
            window_ticks = 16'd100;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_window(input logic [WIN_W-1:0] w);
            window_ticks = w;
        endfunction

        // Value at position k of the ascending order, found by counting ranks.
        function int rank_value(input int vals[$], input int k);
            int less;
            int same;
            for (int i = 0; i < vals.size(); i++) begin
                less = 0;
                same = 0;
                for (int j = 0; j < vals.size(); j++) begin
                    if (vals[j] < vals[i]) begin
                        less++;
                    end else if (vals[j] == vals[i]) begin
                        same++;
                    end
                end
                if (less <= k && k < less + same) begin
                    return vals[i];
                end
            end
            return 0;
        endfunction

        function void take_sample(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic [TIME_W-1:0] t);
            int                xs[$];
            int                ys[$];
            logic [TIME_W-1:0] age;
            median_t           m;
            int                n;
            hist_x[next_slot]    = x;
            hist_y[next_slot]    = y;
            hist_t[next_slot]    = t;
            hist_used[next_slot] = 1'b1;
            next_slot = (next_slot + 1) % HIST_DEPTH;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                if (hist_used[i]) begin
                    age = t - hist_t[i];
                    if (age <= window_ticks) begin
                        xs.push_back(int'(hist_x[i]));
                        ys.push_back(int'(hist_y[i]));
                    end
                end
            end
            n     = xs.size();
            m.mx  = COORD_W'(rank_value(xs, n / 2));
            m.my  = COORD_W'(rank_value(ys, n / 2));
            m.cnt = (n > 255) ? 8'd255 : n[COUNT_W-1:0];
            pending.push_back(m);
        endfunction

        function void check_median(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic [COUNT_W-1:0] n);
            median_t m;
            results_seen++;
            if (pending.size() == 0) begin
                if (errors < SHOWN_ERRORS) begin
                    $display("result %0d with no request outstanding: x=%0d y=%0d n=%0d",
                             results_seen, x, y, n);
                end
                errors++;
            end else begin
                m = pending.pop_front();
                if (m.mx !== x || m.my !== y || m.cnt !== n) begin
                    if (errors < SHOWN_ERRORS) begin
                        $display("result %0d: expected x=%0d y=%0d n=%0d, got x=%0d y=%0d n=%0d",
                                 results_seen, m.mx, m.my, m.cnt, x, y, n);
                    end
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic [WIN_W-1:0]          cfg_wr_data   = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_gaze_x      = '0;
    logic signed [COORD_W-1:0] s_gaze_y      = '0;
    logic [TIME_W-1:0]         s_sample_time = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic signed [COORD_W-1:0] m_median_x;
    logic signed [COORD_W-1:0] m_median_y;
    logic [COUNT_W-1:0]        m_window_count;

    median_board       book;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              hold_req      = 1'b0;
    int                hold_left     = 0;
    int                cycle_count   = 0;
    logic [TIME_W-1:0] stamp_now     = '0;

    timed_window_median_2d #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_gaze_x       (s_gaze_x),
        .s_gaze_y       (s_gaze_y),
        .s_sample_time  (s_sample_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median_x     (m_median_x),
        .m_median_y     (m_median_y),
        .m_window_count (m_window_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side. Outputs are read in the active region just after the edge, so they still
    // hold the values that the edge sampled. A hold request keeps ready low for a long stretch,
    // counted here, so that the block fills up and has to refuse new requests.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            book.check_median(m_median_x, m_median_y, m_window_count);
        end
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request and returns at the edge that accepts it. Valid is left high, so that a
    // following request can go out in the very next cycle; an idle gap lowers it first.
    task automatic offer_sample(input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_gaze_x      <= x;
        s_gaze_y      <= y;
        s_sample_time <= t;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        book.take_sample(x, y, t);
    endtask

    // Drops valid after the last request of a phase and waits until every result is back.
    task automatic close_phase();
        s_valid <= 1'b0;
        while (book.outstanding() != 0) begin
            @(posedge aclk);
        end
    endtask

    // The window register is only written while nothing is in flight.
    task automatic write_window(input logic [WIN_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        book.set_window(w);
        cfg_wr_en <= 1'b0;
    endtask

    // Gaze coordinates mostly cluster round a fixation point, with some full-range values,
    // the extremes and exact repeats of the centre to give ties.
    function automatic logic signed [COORD_W-1:0] pick_coord(input int centre);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) begin
            return COORD_W'(centre + int'($urandom_range(128)) - 64);
        end else if (roll < 80) begin
            return COORD_W'($urandom);
        end else if (roll < 90) begin
            case ($urandom_range(3))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        return COORD_W'(centre);
    endfunction

    // Timestamps mostly creep forward, sometimes repeat, sometimes step back a little, and,
    // when the phase allows it, now and then leap far ahead or anywhere at all.
    function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] now,
                                                     input bit calm);
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) begin
            return now + $urandom_range(1, 3);
        end else if (roll < 78) begin
            return now;
        end else if (roll < 88) begin
            return now + $urandom_range(4, 200);
        end else if (roll < 95 || calm) begin
            return now - $urandom_range(1, 60);
        end else if (roll < 98) begin
            return now + $urandom_range(1000, 70000);
        end
        return $urandom;
    endfunction

    task automatic run_random_phase(input int count, input bit calm);
        int                cx;
        int                cy;
        logic [TIME_W-1:0] t;
        cx = int'($urandom_range(4000)) - 2000;
        cy = int'($urandom_range(4000)) - 2000;
        for (int i = 0; i < count; i++) begin
            // The fixation point wanders now and then, as a saccade would move it.
            if ($urandom_range(99) < 8) begin
                cx = int'($urandom_range(4000)) - 2000;
                cy = int'($urandom_range(4000)) - 2000;
            end
            t = next_stamp(stamp_now, calm);
            stamp_now = t;
            offer_sample(pick_coord(cx), pick_coord(cy), t);
        end
        close_phase();
    endtask

    initial begin
        book = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset window of 100 ticks. The first request sees an
        // empty history, then the window edge is probed at exactly 100 and 101 ticks, a stamp
        // that goes backwards, and a window that straddles the wrap of the timestamp.
        send_idle_pct = 12;
        recv_idle_pct = 82;
        offer_sample(16'sd0, 16'sd0, 32'h0000_0000);
        offer_sample(16'sh7FFF, 16'sh8000, 32'h0000_0000);
        offer_sample(16'sh8000, 16'sh7FFF, 32'd50);
        offer_sample(-16'sd1, 16'sd1, 32'd100);
        offer_sample(16'sd5, -16'sd5, 32'd101);
        offer_sample(16'sd100, 16'sd200, 32'd60);
        offer_sample(16'sd7, 16'sd7, 32'd200);
        offer_sample(16'sd1000, -16'sd1000, 32'hFFFF_FFC0);
        offer_sample(-16'sd2, 16'sd3, 32'hFFFF_FFFF);
        offer_sample(16'sd4, -16'sd4, 32'h0000_0010);
        offer_sample(16'sd9, 16'sd9, 32'h0000_0030);
        offer_sample(16'sh7FFF, 16'sh7FFF, 32'h5555_5555);
        offer_sample(16'sh8000, 16'sh8000, 32'hAAAA_AAAA);
        offer_sample(16'sd12345, -16'sd12345, 32'hAAAA_AAAA);
        close_phase();

        // A zero window keeps only the samples that share the new stamp exactly; the last
        // request here gives an even count and so the upper median.
        write_window(16'd0);
        offer_sample(16'sd1, 16'sd2, 32'hAAAA_AAAA);
        offer_sample(16'sd3, 16'sd4, 32'hAAAA_AAAB);
        offer_sample(16'sd5, 16'sd6, 32'hAAAA_AAAB);
        offer_sample(-16'sd7, -16'sd8, 32'hAAAA_AAAA);
        close_phase();

        // The widest window, with ages of exactly 65535 and 65536 ticks.
        write_window(16'hFFFF);
        offer_sample(16'sd100, -16'sd100, 32'hAAAA_FFFF);
        offer_sample(-16'sd100, 16'sd100, 32'hAAAB_AAA9);
        offer_sample(16'sh5555, 16'shAAAA, 32'hAAAB_AAAB);
        close_phase();
        stamp_now = 32'hAAAB_AAAB;

        // Random requests: a narrow window with a slow receiver first.
        write_window(16'($urandom_range(1, 400)));
        run_random_phase(36, 1'b0);

        // A wide window with a slow sender.
        send_idle_pct = 82;
        recv_idle_pct = 12;
        write_window(16'($urandom_range(1000, 65534)));
        run_random_phase(36, 1'b0);

        // No idling, the widest window and steady stamps, so that the history wraps and fills
        // the window completely. The receiver first holds off long enough for the block to
        // back up and refuse requests.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_window(16'hFFFF);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        run_random_phase(38, 1'b1);

        // Any result beyond those requested would show up within one more request time.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.errors == 0 && book.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
